[hw/rtl/selective_repeat_sender_window_defines.svh]
// ----------------------------------------------------------------------------
// Selective-repeat sender window: assertion macros
// Assertion helpers for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SRSW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SRSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/srsw_pkg.sv]
// ----------------------------------------------------------------------------
// Selective-repeat sender window package
// Widths, codes and shared types of the sender window block.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int unsigned MAX_WINDOW = 32;
  localparam int unsigned WIN_CAP    = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned MAP_W      = 32;
  localparam int unsigned WIN_W      = 6;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned OFF_IDX_W  = 5;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  localparam logic [IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_LAST_SEQ     = 2'd1;
  localparam logic [IDX_W-1:0] CFG_MAX_TIMEOUTS = 2'd2;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    RES_SEND     = 2'd0,
    RES_COMPLETE = 2'd1,
    RES_ABORT    = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK_DELTA,
    ST_LIMIT,
    ST_SCAN,
    ST_EMIT_ONE,
    ST_FLUSH
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             push;
    logic             flush;
    result_kind_e     kind;
    logic [SEQ_W-1:0] seq;
  } obuf_req_t;

endpackage

[hw/rtl/srsw_if.sv]
// ----------------------------------------------------------------------------
// Selective-repeat sender window channels
// Event, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srsw_req_if import srsw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [SEQ_W-1:0] ack_seq;
  logic [SEQ_W-1:0] sel_acks;

  modport source (output valid, req_type, ack_seq, sel_acks, input ready);
  modport sink   (input valid, req_type, ack_seq, sel_acks, output ready);
endinterface

interface srsw_res_if import srsw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       result_kind;
  logic [SEQ_W-1:0] seg_seq;
  logic             last_of_run;

  modport source (output valid, result_kind, seg_seq, last_of_run, input ready);
  modport sink   (input valid, result_kind, seg_seq, last_of_run, output ready);
endinterface

interface srsw_cfg_if import srsw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [SEQ_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/srsw_alu.sv]
// ----------------------------------------------------------------------------
// Selective-repeat sender window shared adder
// One 33-bit add/subtract unit; bit 32 is carry on add, borrow on subtract.
// ----------------------------------------------------------------------------
module srsw_alu import srsw_pkg::*; (
  input  alu_req_t         req_i,
  output logic [SEQ_W:0]   res_o
);

  always_comb begin
    unique case (req_i.op)
      ALU_ADD: res_o = {1'b0, req_i.a} + {1'b0, req_i.b};
      ALU_SUB: res_o = {1'b0, req_i.a} - {1'b0, req_i.b};
      default: res_o = '0;
    endcase
  end

endmodule

[hw/rtl/srsw_obuf.sv]
// ----------------------------------------------------------------------------
// Selective-repeat sender window result buffer
// Holds one result back so the final one of a run can be flagged, then
// drives the registered result channel.
// ----------------------------------------------------------------------------
module srsw_obuf import srsw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  obuf_req_t       req_i,
  output logic            ready_o,
  srsw_res_if.source      res_o
);

  logic             pend_v_q, pend_v_d;
  result_kind_e     pend_kind_q, pend_kind_d;
  logic [SEQ_W-1:0] pend_seq_q, pend_seq_d;
  logic             out_v_q, out_v_d;
  result_kind_e     out_kind_q, out_kind_d;
  logic [SEQ_W-1:0] out_seq_q, out_seq_d;
  logic             out_last_q, out_last_d;
  logic             out_free;

  assign out_free = !out_v_q || res_o.ready;
  assign ready_o  = !pend_v_q || out_free;

  always_comb begin
    pend_v_d    = pend_v_q;
    pend_kind_d = pend_kind_q;
    pend_seq_d  = pend_seq_q;
    out_v_d     = out_v_q && !res_o.ready;
    out_kind_d  = out_kind_q;
    out_seq_d   = out_seq_q;
    out_last_d  = out_last_q;
    if (req_i.push && ready_o) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_kind_d = pend_kind_q;
        out_seq_d  = pend_seq_q;
        out_last_d = 1'b0;
      end
      pend_v_d    = 1'b1;
      pend_kind_d = req_i.kind;
      pend_seq_d  = req_i.seq;
    end else if (req_i.flush && pend_v_q && out_free) begin
      // end of run: the held result is the final one
      out_v_d    = 1'b1;
      out_kind_d = pend_kind_q;
      out_seq_d  = pend_seq_q;
      out_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q <= pend_kind_d;
    pend_seq_q  <= pend_seq_d;
    out_kind_q  <= out_kind_d;
    out_seq_q   <= out_seq_d;
    out_last_q  <= out_last_d;
  end

  assign res_o.valid       = out_v_q;
  assign res_o.result_kind = out_kind_q;
  assign res_o.seg_seq     = out_seq_q;
  assign res_o.last_of_run = out_last_q;

endmodule

[hw/rtl/srsw_ctrl.sv]
// ----------------------------------------------------------------------------
// Selective-repeat sender window sequencer
// Holds configuration and window state, steps the shared adder through
// the ack check, the limit computation and the window scan.
// ----------------------------------------------------------------------------
module srsw_ctrl import srsw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  srsw_req_if.sink        req_i,
  srsw_cfg_if.sink        cfg_i,
  output alu_req_t        alu_req_o,
  input  logic [SEQ_W:0]  alu_res_i,
  output obuf_req_t       obuf_req_o,
  input  logic            obuf_ready_i
);

  state_e             state_q, state_d;
  logic [WIN_W-1:0]   win_size_q;
  logic [SEQ_W-1:0]   last_seq_q;
  logic [CNT_W-1:0]   max_to_q;

  logic [SEQ_W-1:0]   base_q, base_d;
  logic [MAP_W-1:0]   map_q, map_d;
  logic [WIN_W-1:0]   next_off_q, next_off_d;
  logic [CNT_W-1:0]   to_cnt_q, to_cnt_d;
  logic               fin_q, fin_d;
  logic               abort_q, abort_d;

  logic [SEQ_W-1:0]   ack_q, ack_d;
  logic [SEQ_W-1:0]   sel_q, sel_d;
  logic               is_ack_q, is_ack_d;
  logic               carry_q, carry_d;
  logic [WIN_W-1:0]   off_q, off_d;
  logic               lim_none_q, lim_none_d;
  logic [WIN_W-1:0]   lim_q, lim_d;
  result_kind_e       rkind_q, rkind_d;

  logic [WIN_W-1:0]   win;
  logic               req_fire;
  req_type_e          rtype;
  logic               active;
  logic [CNT_W-1:0]   cnt_inc;
  logic               to_abort;
  logic               stale;
  logic               done_ack;
  logic               scan_end;
  logic               hit;

  // effective window, clamped to 1..WIN_CAP
  always_comb begin
    if (win_size_q == '0) begin
      win = WIN_W'(1);
    end else if (win_size_q > WIN_W'(WIN_CAP)) begin
      win = WIN_W'(WIN_CAP);
    end else begin
      win = win_size_q;
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rtype       = req_type_e'(req_i.req_type);
  assign active      = !fin_q && !abort_q;
  assign cnt_inc     = (to_cnt_q < CNT_SAT) ? to_cnt_q + CNT_W'(1) : to_cnt_q;
  assign to_abort    = (cnt_inc >= max_to_q);

  assign stale    = (|alu_res_i[SEQ_W-1:WIN_W]) || (alu_res_i[WIN_W-1:0] > win);
  // ack reach passes last_seq: either the base wrapped or last_seq < new base
  assign done_ack = is_ack_q && (carry_q || alu_res_i[SEQ_W]);
  assign scan_end = (off_q >= win);
  assign hit      = !map_q[off_q[OFF_IDX_W-1:0]] && !lim_none_q && (off_q <= lim_q);

  // shared adder operand select
  always_comb begin
    unique case (state_q)
      ST_ACK_DELTA: alu_req_o = '{op: ALU_SUB, a: ack_q, b: base_q};
      ST_SCAN:      alu_req_o = '{op: ALU_ADD, a: base_q,
                                  b: {{(SEQ_W-WIN_W){1'b0}}, off_q}};
      default:      alu_req_o = '{op: ALU_SUB, a: last_seq_q, b: base_q};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          unique case (rtype)
            REQ_START:   state_d = ST_LIMIT;
            REQ_ACK:     state_d = active ? ST_ACK_DELTA : ST_FLUSH;
            REQ_TIMEOUT: begin
              if (!active) begin
                state_d = ST_FLUSH;
              end else begin
                state_d = to_abort ? ST_EMIT_ONE : ST_LIMIT;
              end
            end
            default:     state_d = ST_FLUSH;
          endcase
        end
      end
      ST_ACK_DELTA: state_d = stale ? ST_FLUSH : ST_LIMIT;
      ST_LIMIT:     state_d = done_ack ? ST_EMIT_ONE : ST_SCAN;
      ST_SCAN:      state_d = scan_end ? ST_FLUSH : ST_SCAN;
      ST_EMIT_ONE:  state_d = obuf_ready_i ? ST_FLUSH : ST_EMIT_ONE;
      ST_FLUSH:     state_d = obuf_ready_i ? ST_IDLE : ST_FLUSH;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    base_d     = base_q;
    map_d      = map_q;
    next_off_d = next_off_q;
    to_cnt_d   = to_cnt_q;
    fin_d      = fin_q;
    abort_d    = abort_q;
    ack_d      = ack_q;
    sel_d      = sel_q;
    is_ack_d   = is_ack_q;
    carry_d    = carry_q;
    off_d      = off_q;
    lim_none_d = lim_none_q;
    lim_d      = lim_q;
    rkind_d    = rkind_q;
    obuf_req_o = '{push: 1'b0, flush: 1'b0, kind: RES_SEND, seq: '0};

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          ack_d    = req_i.ack_seq;
          sel_d    = req_i.sel_acks;
          is_ack_d = (rtype == REQ_ACK);
          carry_d  = 1'b0;
          if (rtype == REQ_START) begin
            base_d     = '0;
            map_d      = '0;
            next_off_d = '0;
            to_cnt_d   = '0;
            fin_d      = 1'b0;
            abort_d    = 1'b0;
          end else if (rtype == REQ_TIMEOUT && active) begin
            to_cnt_d = cnt_inc;
            if (to_abort) begin
              abort_d = 1'b1;
              rkind_d = RES_ABORT;
            end else begin
              next_off_d = '0;
            end
          end
        end
      end
      ST_ACK_DELTA: begin
        if (!stale) begin
          // delta is at most the window here, so bit WIN_W-1 set means a full shift
          map_d = (alu_res_i[WIN_W-1] ? '0 : (map_q >> alu_res_i[OFF_IDX_W-1:0]))
                  | {sel_q[MAP_W-2:0], 1'b0};
          base_d     = ack_q;
          to_cnt_d   = '0;
          next_off_d = win - alu_res_i[WIN_W-1:0];
          carry_d    = alu_res_i[SEQ_W];
        end
      end
      ST_LIMIT: begin
        lim_none_d = alu_res_i[SEQ_W];
        lim_d      = (|alu_res_i[SEQ_W-1:WIN_W]) ? '1 : alu_res_i[WIN_W-1:0];
        off_d      = next_off_q;
        if (done_ack) begin
          fin_d      = 1'b1;
          next_off_d = win;
          rkind_d    = RES_COMPLETE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          next_off_d = win;
        end else begin
          obuf_req_o = '{push: hit, flush: 1'b0, kind: RES_SEND,
                         seq: alu_res_i[SEQ_W-1:0]};
          if (!hit || obuf_ready_i) begin
            off_d = off_q + WIN_W'(1);
          end
        end
      end
      ST_EMIT_ONE: begin
        obuf_req_o = '{push: 1'b1, flush: 1'b0, kind: rkind_q, seq: '0};
      end
      ST_FLUSH: begin
        obuf_req_o = '{push: 1'b0, flush: 1'b1, kind: RES_SEND, seq: '0};
      end
      default: begin
        obuf_req_o = '{push: 1'b0, flush: 1'b0, kind: RES_SEND, seq: '0};
      end
    endcase
  end

  // configuration registers, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WIN_W'(4);
      last_seq_q <= '0;
      max_to_q   <= CNT_W'(3);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_WINDOW_SIZE:  win_size_q <= cfg_i.data[WIN_W-1:0];
        CFG_LAST_SEQ:     last_seq_q <= cfg_i.data;
        CFG_MAX_TIMEOUTS: max_to_q   <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      base_q     <= '0;
      map_q      <= '0;
      next_off_q <= '0;
      to_cnt_q   <= '0;
      fin_q      <= 1'b0;
      abort_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      base_q     <= base_d;
      map_q      <= map_d;
      next_off_q <= next_off_d;
      to_cnt_q   <= to_cnt_d;
      fin_q      <= fin_d;
      abort_q    <= abort_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ack_q      <= ack_d;
    sel_q      <= sel_d;
    is_ack_q   <= is_ack_d;
    carry_q    <= carry_d;
    off_q      <= off_d;
    lim_none_q <= lim_none_d;
    lim_q      <= lim_d;
    rkind_q    <= rkind_d;
  end

endmodule

[hw/rtl/selective_repeat_sender_window.sv]
// ----------------------------------------------------------------------------
// Selective-repeat sender window
// Sender side window of a selective-repeat ARQ transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : events (start, acknowledgement, timeout). One event is taken at a
//            time; ready stays low until every result of the event is handed
//            to the result buffer.
//   res_o  : results (segment to send, transfer complete, aborted), one per
//            transfer, last_of_run set on the final result of an event. An
//            event may produce no result at all.
//   cfg_i  : register writes (window size, last_seq, max_timeouts), always
//            ready; write only while no event is in flight.
//   Timing: the window scan checks one slot per cycle through the shared
//   adder while the result buffer accepts its sends.
//   A stalled receiver holds the scan once the one-entry hold stage and the
//   output register are both full.
//   Reset: window of 4, last_seq 0, max_timeouts 3, window state cleared.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window import srsw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  srsw_req_if.sink    req_i,
  srsw_res_if.source  res_o,
  srsw_cfg_if.sink    cfg_i
);

  alu_req_t        alu_req;
  logic [SEQ_W:0]  alu_res;
  obuf_req_t       obuf_req;
  logic            obuf_ready;

  srsw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_i        (cfg_i),
    .alu_req_o    (alu_req),
    .alu_res_i    (alu_res),
    .obuf_req_o   (obuf_req),
    .obuf_ready_i (obuf_ready)
  );

  srsw_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  srsw_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (obuf_req),
    .ready_o (obuf_ready),
    .res_o   (res_o)
  );

endmodule

[hw/rtl/srsw_checker.sv]
// ----------------------------------------------------------------------------
// Selective-repeat sender window checker
// Port-level checks of the sender window, bound to the top level.
// ----------------------------------------------------------------------------
`include "selective_repeat_sender_window_defines.svh"

module srsw_checker import srsw_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic [1:0]       res_kind_i,
  input logic [SEQ_W-1:0] res_seq_i,
  input logic             res_last_i
);

  `SRSW_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "event accepted while previous still in work")
  `SRSW_ASSERT_IMPL(a_status_last, clk_i, rst_ni, res_valid_i && res_kind_i != RES_SEND, res_last_i && res_seq_i == '0, "status result not a single final result")
  `SRSW_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i, "result dropped while stalled")
  `SRSW_ASSERT_NEXT(a_res_stable, clk_i, rst_ni, res_valid_i && !res_ready_i, $stable(res_seq_i) && $stable(res_last_i), "result changed while stalled")

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_kind_i  (res_o.result_kind),
  .res_seq_i   (res_o.seg_seq),
  .res_last_i  (res_o.last_of_run)
);

[tb/srsw_window_checker.sv]
// ----------------------------------------------------------------------------
// Sender window checker
// Watches the config, event and result channels of the sender window, keeps
// its own copy of the window state and compares every result transfer
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module srsw_window_checker import srsw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  srsw_req_if         req,
  srsw_res_if         res,
  srsw_cfg_if         cfg,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  typedef struct packed {
    result_kind_e     kind;
    logic [SEQ_W-1:0] seq;
    logic             run_end;
  } tx_result_t;

  tx_result_t owed_results[$];
  tx_result_t event_run[$];

  // register copies
  logic [WIN_W-1:0] cfg_window;
  logic [SEQ_W-1:0] cfg_last_seq;
  logic [CNT_W-1:0] cfg_max_to;

  // window state copies
  logic [SEQ_W-1:0] base;
  logic [MAP_W-1:0] acked_map;
  logic [WIN_W-1:0] next_off;
  logic [CNT_W-1:0] to_count;
  logic             done;
  logic             gave_up;

  function automatic int unsigned eff_window();
    if (cfg_window == '0) return 1;
    if (cfg_window > WIN_CAP) return WIN_CAP;
    return cfg_window;
  endfunction

  // sends every slot from next_off up, skipping acked ones and those past last_seq
  function automatic void queue_window_sends();
    int unsigned  w;
    logic [SEQ_W:0] seq;
    w = eff_window();
    for (int unsigned off = next_off; off < w; off++) begin
      seq = {1'b0, base} + (SEQ_W+1)'(off);
      if (!acked_map[off] && seq <= {1'b0, cfg_last_seq})
        event_run.push_back('{kind: RES_SEND, seq: seq[SEQ_W-1:0], run_end: 1'b0});
    end
    next_off = WIN_W'(w);
  endfunction

  function automatic void schedule_event(logic [1:0] kind, logic [SEQ_W-1:0] ack,
                                         logic [SEQ_W-1:0] sel);
    int unsigned    w;
    logic [SEQ_W-1:0] delta;
    logic [SEQ_W:0] reach;
    event_run.delete();
    w = eff_window();
    case (kind)
      REQ_START: begin
        base      = '0;
        acked_map = '0;
        next_off  = '0;
        to_count  = '0;
        done      = 1'b0;
        gave_up   = 1'b0;
        queue_window_sends();
      end
      REQ_ACK: begin
        delta = ack - base;
        if (!done && !gave_up && delta <= w) begin
          reach     = {1'b0, base} + {1'b0, delta};
          acked_map = (acked_map >> delta) | (sel << 1);
          base      = ack;
          to_count  = '0;
          next_off  = WIN_W'(w - delta);
          if (reach > {1'b0, cfg_last_seq}) begin
            done     = 1'b1;
            next_off = WIN_W'(w);
            event_run.push_back('{kind: RES_COMPLETE, seq: '0, run_end: 1'b0});
          end else begin
            queue_window_sends();
          end
        end
      end
      REQ_TIMEOUT: begin
        if (!done && !gave_up) begin
          if (to_count != CNT_SAT) to_count++;
          if (to_count >= cfg_max_to) begin
            gave_up = 1'b1;
            event_run.push_back('{kind: RES_ABORT, seq: '0, run_end: 1'b0});
          end else begin
            next_off = '0;
            queue_window_sends();
          end
        end
      end
      default: ;
    endcase
    if (event_run.size() > 0) begin
      event_run[event_run.size()-1].run_end = 1'b1;
      foreach (event_run[i]) owed_results.push_back(event_run[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tx_result_t exp_res;
    if (!rst_ni) begin
      cfg_window   = 6'd4;
      cfg_last_seq = '0;
      cfg_max_to   = 4'd3;
      base         = '0;
      acked_map    = '0;
      next_off     = '0;
      to_count     = '0;
      done         = 1'b0;
      gave_up      = 1'b0;
      owed_results.delete();
      errors_o     = 0;
      pending_o    = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_WINDOW_SIZE:  cfg_window   = cfg.data[WIN_W-1:0];
          CFG_LAST_SEQ:     cfg_last_seq = cfg.data;
          CFG_MAX_TIMEOUTS: cfg_max_to   = cfg.data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (owed_results.size() == 0) begin
          $error("result with nothing expected: result_kind %0d seg_seq %0d last_of_run %0d",
                 res.result_kind, res.seg_seq, res.last_of_run);
          errors_o++;
        end else begin
          exp_res = owed_results.pop_front();
          if (res.result_kind !== exp_res.kind) begin
            $error("result_kind mismatch: expected %0d, actual %0d",
                   exp_res.kind, res.result_kind);
            errors_o++;
          end
          if (res.seg_seq !== exp_res.seq) begin
            $error("seg_seq mismatch: expected %0d, actual %0d", exp_res.seq, res.seg_seq);
            errors_o++;
          end
          if (res.last_of_run !== exp_res.run_end) begin
            $error("last_of_run mismatch: expected %0d, actual %0d",
                   exp_res.run_end, res.last_of_run);
            errors_o++;
          end
        end
      end
      if (req.valid && req.ready)
        schedule_event(req.req_type, req.ack_seq, req.sel_acks);
      pending_o = owed_results.size();
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Sender window testbench
// Drives start, ack and timeout events into the selective-repeat sender
// window under several register settings, with random gaps on both sides
// and one long result stall; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import srsw_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  srsw_req_if req ();
  srsw_res_if res ();
  srsw_cfg_if cfg ();

  int unsigned errors;
  int unsigned pending;

  bit calm;
  bit stall_once;

  // stimulus-side view of the transfer, used to shape well-formed acks
  logic [SEQ_W-1:0] cur_base;
  logic [SEQ_W-1:0] last_cp;
  int unsigned      win_cp;
  int unsigned      max_cp;
  int unsigned      tmo_run;
  bit               over;

  selective_repeat_sender_window dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  srsw_window_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req),
    .res       (res),
    .cfg       (cfg),
    .errors_o  (errors),
    .pending_o (pending)
  );

  task automatic send_event(logic [1:0] kind, logic [SEQ_W-1:0] ack, logic [SEQ_W-1:0] sel);
    while (!calm && $urandom_range(99) < 9) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid    <= 1'b1;
    req.req_type <= kind;
    req.ack_seq  <= ack;
    req.sel_acks <= sel;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic send_start();
    send_event(REQ_START, $urandom, $urandom);
    cur_base = '0;
    tmo_run  = 0;
    over     = 1'b0;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [SEQ_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every owed result, then let ignored events drain
  task automatic settle();
    req.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(logic [WIN_W-1:0] ws, logic [SEQ_W-1:0] ls,
                              logic [CNT_W-1:0] mt);
    settle();
    write_reg(CFG_WINDOW_SIZE, SEQ_W'(ws));
    write_reg(CFG_LAST_SEQ, ls);
    write_reg(CFG_MAX_TIMEOUTS, SEQ_W'(mt));
    win_cp  = (ws == 0) ? 1 : ((ws > WIN_CAP) ? WIN_CAP : ws);
    last_cp = ls;
    max_cp  = mt;
  endtask

  function automatic logic [SEQ_W-1:0] pick_sel();
    case ($urandom_range(3))
      0:       return '0;
      1:       return $urandom;
      2:       return $urandom & $urandom;
      default: return $urandom | $urandom;
    endcase
  endfunction

  task automatic run_phase(int unsigned target);
    int unsigned      live_items;
    int unsigned      r;
    int unsigned      delta;
    logic [SEQ_W-1:0] ack;
    live_items = 1;
    send_start();
    while (live_items < target) begin
      if (over) begin
        // sometimes poke the finished/aborted transfer before restarting
        if ($urandom_range(3) == 0)
          send_event($urandom_range(1) ? REQ_TIMEOUT : REQ_ACK, cur_base + 1, $urandom);
        send_start();
        live_items++;
        continue;
      end
      r = $urandom_range(99);
      if (r < 70) begin
        delta = $urandom_range(win_cp);
        send_event(REQ_ACK, cur_base + delta, pick_sel());
        cur_base = cur_base + delta;
        tmo_run  = 0;
        if (cur_base > last_cp) over = 1'b1;
        live_items++;
      end else if (r < 82) begin
        send_event(REQ_TIMEOUT, $urandom, $urandom);
        if (tmo_run < 15) tmo_run++;
        if (tmo_run >= max_cp) over = 1'b1;
        live_items++;
      end else if (r < 88) begin
        send_event(REQ_ACK, $urandom, $urandom);
      end else if (r < 91) begin
        send_event(REQ_UNKNOWN, $urandom, $urandom);
      end else if (r < 96) begin
        // oversized or stale ack
        if ($urandom_range(1))
          ack = cur_base + win_cp + 1 + $urandom_range(3);
        else
          ack = cur_base - 1 - $urandom_range(7);
        send_event(REQ_ACK, ack, $urandom);
      end else begin
        send_start();
        live_items++;
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_once) begin
        stall_once = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        res.ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    req.valid    = 1'b0;
    req.req_type = '0;
    req.ack_seq  = '0;
    req.sel_acks = '0;
    cfg.valid    = 1'b0;
    cfg.index    = '0;
    cfg.data     = '0;
    calm         = 1'b0;
    stall_once   = 1'b0;
    win_cp       = 4;
    last_cp      = '0;
    max_cp       = 3;
    cur_base     = '0;
    tmo_run      = 0;
    over         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window 4, last_seq 0, max_timeouts 3
    send_start();
    send_event(REQ_ACK, 32'd0, 32'd0);               // zero delta, nothing new opens
    send_event(REQ_TIMEOUT, '1, '1);
    send_event(REQ_TIMEOUT, 32'd0, 32'd0);
    send_event(REQ_TIMEOUT, 32'd0, 32'd0);           // third in a row aborts
    send_event(REQ_TIMEOUT, 32'd0, 32'd0);           // aborted: silent
    send_event(REQ_ACK, 32'd1, 32'd0);
    send_event(REQ_UNKNOWN, '1, '1);
    send_start();
    send_event(REQ_ACK, 32'd1, 32'd0);               // base passes last_seq
    send_event(REQ_TIMEOUT, 32'd0, 32'd0);

    apply_config(6'd32, '1, 4'd15);
    send_start();
    send_event(REQ_ACK, 32'd32, '1);                 // full slide, all selective bits
    send_event(REQ_ACK, 32'd31, 32'd0);              // stale
    send_event(REQ_ACK, 32'd65, 32'd0);              // one past the window
    send_event(REQ_ACK, 32'd64, 32'h8000_0000);      // top selective bit dropped
    send_event(REQ_ACK, 32'd64, 32'h5555_5555);
    send_event(REQ_TIMEOUT, 32'd0, 32'd0);

    // shrink the window under a live transfer
    settle();
    write_reg(CFG_WINDOW_SIZE, 32'd0);
    win_cp = 1;
    send_event(REQ_ACK, 32'd66, 32'd0);
    send_event(REQ_ACK, 32'd65, 32'd0);
    send_event(REQ_TIMEOUT, 32'd0, 32'd0);

    apply_config(6'd0, 32'd3, 4'd0);
    send_start();
    send_event(REQ_TIMEOUT, 32'd0, 32'd0);           // zero limit aborts at once
    send_start();
    send_event(REQ_ACK, 32'd1, 32'd0);
    send_event(REQ_ACK, 32'd3, 32'd0);

    apply_config(6'd5, 32'd40, 4'd3);
    run_phase(48);
    apply_config(6'd32, 32'd200, 4'd15);
    stall_once = 1'b1;
    run_phase(48);
    apply_config(6'd1, 32'd30, 4'd2);
    run_phase(48);
    apply_config(6'd63, 32'd300, 4'd4);
    calm = 1'b1;
    run_phase(48);
    calm = 1'b0;
    apply_config(6'd17, '1, 4'd7);
    run_phase(48);
    apply_config(6'd8, 32'd100, 4'd0);
    run_phase(48);

    settle();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/srsw_pkg.sv
hw/rtl/srsw_if.sv
hw/rtl/srsw_alu.sv
hw/rtl/srsw_obuf.sv
hw/rtl/srsw_ctrl.sv
hw/rtl/selective_repeat_sender_window.sv
hw/rtl/srsw_checker.sv
tb/srsw_window_checker.sv
tb/testbench.sv
